// ----- hw/rtl/normal_filtered_nearest_point_core_macros.svh -----
// assertion helpers shared by the rtl
`ifndef NORMAL_FILTERED_NEAREST_POINT_CORE_MACROS_SVH
`define NORMAL_FILTERED_NEAREST_POINT_CORE_MACROS_SVH

// plain property checked on every clock edge outside reset
`define NFNP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define NFNP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define NFNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/nfnp_pkg.sv -----
`timescale 1ns / 1ps

package nfnp_pkg;

	// defaults for the top level parameters
	localparam int TARGET_DEPTH_DEF = 1024;
	localparam int COORD_WIDTH_DEF  = 16;

	// fixed field widths
	localparam int OP_W       = 1;
	localparam int SLOT_W     = 10;
	localparam int NORM_W     = 16;
	localparam int COUNT_W    = 11;
	localparam int INDEX_W    = 10;
	localparam int RES_DIST_W = 34;

	// dot product of two normals: three 32-bit products summed
	localparam int PROD_W = 2 * NORM_W;
	localparam int DOT_W  = PROD_W + 2;

	// item opcodes
	localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
	localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

// ----- hw/rtl/nfnp_ram.sv -----
`timescale 1ns / 1ps

module nfnp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/normal_filtered_nearest_point_core.sv -----
`timescale 1ns / 1ps
// Normal-filtered nearest target point search.
// Input channel src_valid/src_ready carries one item: op selects a load or a query.
// A load writes position and normal into table entry target_slot in the cycle it is
// accepted (slots at or beyond TARGET_DEPTH are dropped) and gives no result.
// A query scans entries 0 .. target_count-1 (saturated to TARGET_DEPTH), skips
// entries whose normal has a non-positive dot product with the query normal, and
// returns found, match_index and best_distance of the closest one, lowest index
// first on a tie, on the res_valid/res_ready channel.
// A load leaves the block idle; a query keeps src_ready low from its acceptance until
// its result is passed to the output register, while the single read port of the
// table feeds one entry per cycle to a three-stage product / sum / compare pipeline
// behind it.
// The result sits in an output register, so the next item is taken while a result
// waits; a query that finishes while that register is still full holds until
// res_ready frees it.
// target_count is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. Reset clears target_count
// and all control state; the table contents stay undefined until loaded.

module normal_filtered_nearest_point_core #(
	parameter int TARGET_DEPTH = nfnp_pkg::TARGET_DEPTH_DEF,
	parameter int COORD_WIDTH  = nfnp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [nfnp_pkg::COUNT_W-1:0]         cfg_wdata,
	// item input
	input  logic                                 src_valid,
	output logic                                 src_ready,
	input  logic [nfnp_pkg::OP_W-1:0]            op,
	input  logic [nfnp_pkg::SLOT_W-1:0]          target_slot,
	input  logic signed [COORD_WIDTH-1:0]        pos_x,
	input  logic signed [COORD_WIDTH-1:0]        pos_y,
	input  logic signed [COORD_WIDTH-1:0]        pos_z,
	input  logic signed [nfnp_pkg::NORM_W-1:0]   norm_x,
	input  logic signed [nfnp_pkg::NORM_W-1:0]   norm_y,
	input  logic signed [nfnp_pkg::NORM_W-1:0]   norm_z,
	// result output
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic                                 found,
	output logic [nfnp_pkg::INDEX_W-1:0]         match_index,
	output logic [nfnp_pkg::RES_DIST_W-1:0]      best_distance
);

	import nfnp_pkg::*;

	localparam int AW      = $clog2(TARGET_DEPTH);
	localparam int CW      = $clog2(TARGET_DEPTH + 1);
	localparam int POS_RW  = 3 * COORD_WIDTH;
	localparam int NORM_RW = 3 * NORM_W;
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int DIST_W  = SQ_W + 2;
	localparam int EXT_W   = (DIST_W > RES_DIST_W) ? DIST_W : RES_DIST_W;
	localparam logic [RES_DIST_W-1:0] DIST_MAX = '1;

	state_t state_q;

	logic [COUNT_W-1:0] target_count_q;

	// query latched at acceptance
	logic signed [COORD_WIDTH-1:0] qpos_x_q, qpos_y_q, qpos_z_q;
	logic signed [NORM_W-1:0]      qnorm_x_q, qnorm_y_q, qnorm_z_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 rd_idx_q;

	// scan pipeline
	logic                   v_s1, v_s2, v_s3;
	logic [AW-1:0]          idx_s1, idx_s2, idx_s3;
	logic signed [PROD_W-1:0] dp_x_s2, dp_y_s2, dp_z_s2;
	logic [SQ_W-1:0]        sq_x_s2, sq_y_s2, sq_z_s2;
	logic                   dot_pos_s3;
	logic [DIST_W-1:0]      dist_s3;

	// running best
	logic              found_q;
	logic [AW-1:0]     best_idx_q;
	logic [DIST_W-1:0] best_q;

	// output register
	logic                  res_valid_q;
	logic                  res_found_q;
	logic [INDEX_W-1:0]    res_index_q;
	logic [RES_DIST_W-1:0] res_dist_q;

	logic                  src_fire;
	logic                  load_we;
	logic                  rd_en;
	logic                  scan_end;
	logic                  done_fire;
	logic [CW-1:0]         count_sat;
	logic [POS_RW-1:0]     pos_rdata;
	logic [NORM_RW-1:0]    norm_rdata;
	logic signed [COORD_WIDTH-1:0] tpos_x, tpos_y, tpos_z;
	logic signed [NORM_W-1:0]      tnorm_x, tnorm_y, tnorm_z;
	logic signed [DIFF_W-1:0]      diff_x, diff_y, diff_z;
	logic signed [SQ_W-1:0]        sq_x, sq_y, sq_z;
	logic signed [DOT_W-1:0]       dot_sum;
	logic [EXT_W-1:0]              best_ext;
	logic [RES_DIST_W-1:0]         best_sat;

	// handshake and control decode
	assign src_ready = (state_q == ST_IDLE);
	assign src_fire  = src_valid && src_ready;
	assign load_we   = src_fire && (op == OP_LOAD)
		&& (32'(target_slot) < 32'(TARGET_DEPTH));
	assign rd_en     = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign scan_end  = (state_q == ST_SCAN) && (rd_idx_q == count_q)
		&& !v_s1 && !v_s2 && !v_s3;
	assign done_fire = (state_q == ST_DONE) && (!res_valid_q || res_ready);
	assign count_sat = (32'(target_count_q) > 32'(TARGET_DEPTH)) ?
		CW'(TARGET_DEPTH) : CW'(target_count_q);

	// target table: positions and normals
	nfnp_ram #(
		.WIDTH(POS_RW),
		.DEPTH(TARGET_DEPTH)
	) u_pos_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(AW'(target_slot)),
		.wdata({pos_z, pos_y, pos_x}),
		.re   (rd_en),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(pos_rdata)
	);

	nfnp_ram #(
		.WIDTH(NORM_RW),
		.DEPTH(TARGET_DEPTH)
	) u_norm_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(AW'(target_slot)),
		.wdata({norm_z, norm_y, norm_x}),
		.re   (rd_en),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(norm_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_count_q <= '0;
		end else if (cfg_we) begin
			target_count_q <= cfg_wdata;
		end
	end

	// controller and read address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (src_fire && (op == OP_QUERY)) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
						count_q  <= count_sat;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query operands
	always_ff @(posedge clk) begin
		if (src_fire && (op == OP_QUERY)) begin
			qpos_x_q  <= pos_x;
			qpos_y_q  <= pos_y;
			qpos_z_q  <= pos_z;
			qnorm_x_q <= norm_x;
			qnorm_y_q <= norm_y;
			qnorm_z_q <= norm_z;
		end
	end

	// unpack table read data
	assign tpos_x  = pos_rdata[0*COORD_WIDTH +: COORD_WIDTH];
	assign tpos_y  = pos_rdata[1*COORD_WIDTH +: COORD_WIDTH];
	assign tpos_z  = pos_rdata[2*COORD_WIDTH +: COORD_WIDTH];
	assign tnorm_x = norm_rdata[0*NORM_W +: NORM_W];
	assign tnorm_y = norm_rdata[1*NORM_W +: NORM_W];
	assign tnorm_z = norm_rdata[2*NORM_W +: NORM_W];

	// coordinate differences and their squares
	assign diff_x = DIFF_W'(qpos_x_q) - DIFF_W'(tpos_x);
	assign diff_y = DIFF_W'(qpos_y_q) - DIFF_W'(tpos_y);
	assign diff_z = DIFF_W'(qpos_z_q) - DIFF_W'(tpos_z);
	assign sq_x   = diff_x * diff_x;
	assign sq_y   = diff_y * diff_y;
	assign sq_z   = diff_z * diff_z;

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1 index tracks the read in flight
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_idx_q[AW-1:0];
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (v_s1) begin
			idx_s2  <= idx_s1;
			dp_x_s2 <= qnorm_x_q * tnorm_x;
			dp_y_s2 <= qnorm_y_q * tnorm_y;
			dp_z_s2 <= qnorm_z_q * tnorm_z;
			sq_x_s2 <= sq_x;
			sq_y_s2 <= sq_y;
			sq_z_s2 <= sq_z;
		end
	end

	// stage 3: sums
	assign dot_sum = DOT_W'(dp_x_s2) + DOT_W'(dp_y_s2) + DOT_W'(dp_z_s2);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			idx_s3     <= idx_s2;
			dot_pos_s3 <= !dot_sum[DOT_W-1] && (dot_sum != '0);
			dist_s3    <= DIST_W'(sq_x_s2) + DIST_W'(sq_y_s2) + DIST_W'(sq_z_s2);
		end
	end

	// best candidate, strict compare keeps the lowest index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (src_fire && (op == OP_QUERY)) begin
			found_q <= 1'b0;
		end else if (v_s3 && dot_pos_s3) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && dot_pos_s3 && (!found_q || (dist_s3 < best_q))) begin
			best_q     <= dist_s3;
			best_idx_q <= idx_s3;
		end
	end

	// saturate the distance to the result width
	assign best_ext = EXT_W'(best_q);
	assign best_sat = (best_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : best_ext[RES_DIST_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			res_found_q <= found_q;
			res_index_q <= found_q ? INDEX_W'(best_idx_q) : '0;
			res_dist_q  <= found_q ? best_sat : '0;
		end
	end

	assign res_valid     = res_valid_q;
	assign found         = res_found_q;
	assign match_index   = res_index_q;
	assign best_distance = res_dist_q;

	// checks
`include "normal_filtered_nearest_point_core_macros.svh"

	`NFNP_ASSERT_IMP(a_pipe_in_scan, clk, arst_n, v_s1 || v_s2 || v_s3, state_q == ST_SCAN, "pipeline busy outside scan")
	`NFNP_ASSERT_IMP(a_read_in_range, clk, arst_n, v_s1, 32'(idx_s1) < 32'(count_q), "table read beyond scan count")
	`NFNP_ASSERT_NEXT(a_result_from_done, clk, arst_n, done_fire, res_valid_q && (state_q == ST_IDLE), "finished query not presented")
	`NFNP_ASSERT_IMP(a_not_found_zero, clk, arst_n, res_valid_q && !res_found_q, (res_index_q == '0) && (res_dist_q == '0), "miss result carries nonzero fields")

endmodule
